// ===== design/greedy_change_dispenser_core_macros.svh =====
// ----------------------------------------------------------------------------
// greedy change dispenser assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_DISPENSER_CORE_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_CORE_MACROS_SVH

// same-cycle implication
`define GCHG_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GCHG_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/gchg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_pkg
// types, constants and reset table of the greedy change dispenser
// ----------------------------------------------------------------------------
package gchg_pkg;

  localparam int NUM_DENOMS    = 7;
  localparam int NUM_REGS      = 7;
  localparam int VALUE_W       = 20;
  localparam int AMT_W         = 24;
  localparam int CNT_W         = 8;
  localparam int STAT_W        = 3;
  localparam int IDX_OUT_W     = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int IDX_W         = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int BIT_W         = $clog2(CNT_W);
  localparam int PROD_W        = VALUE_W + CNT_W;
  localparam int TOT_W         = PROD_W + $clog2(NUM_DENOMS + 1);
  localparam int SUB_W         = VALUE_W + CNT_W - 1;
  localparam logic [CNT_W-1:0] INITIAL_STOCK = CNT_W'(10);

  typedef enum logic [STAT_W-1:0] {
    ST_ISSUED = 3'd0,
    ST_EXACT  = 3'd1,
    ST_ZERO   = 3'd2,
    ST_SHORT  = 3'd3,
    ST_DRAWER = 3'd4
  } code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT_MUL,
    S_TOT_ACC,
    S_CHECK,
    S_WALK,
    S_STORE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic  load_sale;
    logic  clr_idx;
    logic  inc_idx;
    logic  tot_mul;
    logic  tot_acc;
    logic  rest_load;
    logic  walk_init;
    logic  walk_step;
    logic  walk_store;
    logic  out_load;
    code_t out_code;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic bit_zero;
    logic zero_amt;
    logic drawer_short;
    logic pay_short;
    logic exact;
    logic cnt_nz;
    logic later_nz;
    logic any_nz;
    logic out_free;
  } sts_t;

  function automatic logic [VALUE_W-1:0] reset_value(input int i);
    case (i)
      0:       return VALUE_W'(100000);
      1:       return VALUE_W'(50000);
      2:       return VALUE_W'(20000);
      3:       return VALUE_W'(10000);
      4:       return VALUE_W'(5000);
      5:       return VALUE_W'(2000);
      6:       return VALUE_W'(1000);
      default: return '0;
    endcase
  endfunction

endpackage

// ===== design/gchg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg channel interfaces
// sale input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
interface gchg_sale_if;
  logic                        valid;
  logic                        ready;
  logic [gchg_pkg::AMT_W-1:0]  price;
  logic [gchg_pkg::AMT_W-1:0]  paid;
  modport source (output valid, price, paid, input ready);
  modport sink   (input valid, price, paid, output ready);
endinterface

interface gchg_result_if;
  logic                            valid;
  logic                            ready;
  logic [gchg_pkg::STAT_W-1:0]     status;
  logic [gchg_pkg::IDX_OUT_W-1:0]  denom_index;
  logic [gchg_pkg::CNT_W-1:0]      note_count;
  logic [gchg_pkg::AMT_W-1:0]      change_due;
  logic [gchg_pkg::AMT_W-1:0]      unpaid_rest;
  logic                            last;
  modport source (output valid, status, denom_index, note_count, change_due,
                  unpaid_rest, last, input ready);
  modport sink   (input valid, status, denom_index, note_count, change_due,
                  unpaid_rest, last, output ready);
endinterface

// ===== design/greedy_change_dispenser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_dispenser_core
// greedy change payout from a limited note stock, one sale at a time
// ----------------------------------------------------------------------------
// channel   dir  payload                                          transfer
// sale      in   price, paid                                      valid & ready
// result    out  status, denom_index, note_count, change_due,     valid & ready
//                unpaid_rest, last
// cfg       in   cfg_index, cfg_data                              cfg_wr_en
//
// a sale runs the drawer total (a multiply and an accumulate step per
// denomination on one shared multiplier), a check step, then for each
// denomination a bounded divide (one quotient bit per cycle) and a store
// step, then a scan of up to NUM_DENOMS result entries; a rejected or exact
// sale ends after the check; no clearing pass: stock, values reset at once
// sale.ready is high only between sales; a stalled result holds the sequencer
// ----------------------------------------------------------------------------
module greedy_change_dispenser_core (
  input  logic                           clk,
  input  logic                           rst,
  gchg_sale_if.sink                      sale,
  gchg_result_if.source                  result,
  input  logic                           cfg_wr_en,
  input  logic [gchg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gchg_pkg::VALUE_W-1:0]   cfg_data
);

  gchg_pkg::cmd_t cmd;
  gchg_pkg::sts_t sts;

  gchg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .sale_valid (sale.valid),
    .sale_ready (sale.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gchg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sale_price      (sale.price),
    .sale_paid       (sale.paid),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_status      (result.status),
    .out_denom_index (result.denom_index),
    .out_note_count  (result.note_count),
    .out_change_due  (result.change_due),
    .out_unpaid_rest (result.unpaid_rest),
    .out_last        (result.last)
  );

endmodule

// ===== design/gchg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_ctrl
// sequencer: drawer total, checks, greedy walk and result scan
// ----------------------------------------------------------------------------
module gchg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           sale_valid,
  output logic           sale_ready,
  input  gchg_pkg::sts_t sts,
  output gchg_pkg::cmd_t cmd
);

  gchg_pkg::state_t state;
  gchg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gchg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_code = gchg_pkg::ST_ISSUED;
    sale_ready   = 1'b0;
    case (state)
      gchg_pkg::S_IDLE: begin
        sale_ready = !rst;
        if (sale_valid && !rst) begin
          cmd.load_sale = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_next    = gchg_pkg::S_TOT_MUL;
        end
      end
      gchg_pkg::S_TOT_MUL: begin
        cmd.tot_mul = 1'b1;
        state_next  = gchg_pkg::S_TOT_ACC;
      end
      gchg_pkg::S_TOT_ACC: begin
        cmd.tot_acc = 1'b1;
        if (sts.idx_last) begin
          state_next = gchg_pkg::S_CHECK;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = gchg_pkg::S_TOT_MUL;
        end
      end
      gchg_pkg::S_CHECK: begin
        if (sts.zero_amt) begin
          cmd.out_code = gchg_pkg::ST_ZERO;
        end else if (sts.drawer_short) begin
          cmd.out_code = gchg_pkg::ST_DRAWER;
        end else if (sts.pay_short) begin
          cmd.out_code = gchg_pkg::ST_SHORT;
        end else begin
          cmd.out_code = gchg_pkg::ST_EXACT;
        end
        if (sts.zero_amt || sts.drawer_short || sts.pay_short || sts.exact) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = gchg_pkg::S_IDLE;
          end
        end else begin
          cmd.rest_load = 1'b1;
          cmd.clr_idx   = 1'b1;
          cmd.walk_init = 1'b1;
          state_next    = gchg_pkg::S_WALK;
        end
      end
      gchg_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.bit_zero) begin
          state_next = gchg_pkg::S_STORE;
        end
      end
      gchg_pkg::S_STORE: begin
        cmd.walk_store = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_next  = gchg_pkg::S_SCAN;
        end else begin
          cmd.inc_idx   = 1'b1;
          cmd.walk_init = 1'b1;
          state_next    = gchg_pkg::S_WALK;
        end
      end
      gchg_pkg::S_SCAN: begin
        cmd.out_code = gchg_pkg::ST_ISSUED;
        if (sts.cnt_nz || !sts.any_nz) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            if (sts.later_nz) begin
              cmd.inc_idx = 1'b1;
            end else begin
              state_next = gchg_pkg::S_IDLE;
            end
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      default: begin
        state_next = gchg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/gchg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_dp
// denomination registers, note stock, total accumulator, bit-serial
// bounded divider and result register
// ----------------------------------------------------------------------------
module gchg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [gchg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gchg_pkg::VALUE_W-1:0]      cfg_data,
  input  logic [gchg_pkg::AMT_W-1:0]        sale_price,
  input  logic [gchg_pkg::AMT_W-1:0]        sale_paid,
  input  gchg_pkg::cmd_t                    cmd,
  output gchg_pkg::sts_t                    sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [gchg_pkg::STAT_W-1:0]       out_status,
  output logic [gchg_pkg::IDX_OUT_W-1:0]    out_denom_index,
  output logic [gchg_pkg::CNT_W-1:0]        out_note_count,
  output logic [gchg_pkg::AMT_W-1:0]        out_change_due,
  output logic [gchg_pkg::AMT_W-1:0]        out_unpaid_rest,
  output logic                              out_last
);

  logic [gchg_pkg::VALUE_W-1:0] value [gchg_pkg::NUM_DENOMS];
  logic [gchg_pkg::CNT_W-1:0]   stock [gchg_pkg::NUM_DENOMS];
  logic [gchg_pkg::CNT_W-1:0]   cnt   [gchg_pkg::NUM_DENOMS];

  logic [gchg_pkg::AMT_W-1:0]   price;
  logic [gchg_pkg::AMT_W-1:0]   paid;
  logic [gchg_pkg::TOT_W-1:0]   acc;
  logic [gchg_pkg::PROD_W-1:0]  prod;
  logic [gchg_pkg::IDX_W-1:0]   idx;
  logic [gchg_pkg::BIT_W-1:0]   bitn;
  logic [gchg_pkg::CNT_W-1:0]   q;
  logic [gchg_pkg::AMT_W-1:0]   rest;

  logic [gchg_pkg::VALUE_W-1:0] cur_value;
  logic [gchg_pkg::CNT_W-1:0]   cur_stock;
  logic [gchg_pkg::AMT_W-1:0]   change;
  logic [gchg_pkg::SUB_W-1:0]   sub;
  logic [gchg_pkg::CNT_W-1:0]   trial;
  logic                         take;
  logic                         later_nz;
  logic                         any_nz;

  assign cur_value = value[idx];
  assign cur_stock = stock[idx];
  assign change    = paid - price;
  assign sub       = gchg_pkg::SUB_W'(cur_value) << bitn;
  assign trial     = q | (gchg_pkg::CNT_W'(1) << bitn);
  assign take      = (cur_value != '0) && (gchg_pkg::SUB_W'(rest) >= sub) &&
                     (trial <= cur_stock);

  always_comb begin
    later_nz = 1'b0;
    any_nz   = 1'b0;
    for (int j = 0; j < gchg_pkg::NUM_DENOMS; j++) begin
      if (cnt[j] != '0) begin
        any_nz = 1'b1;
        if (j > int'(idx)) begin
          later_nz = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.idx_last     = (idx == gchg_pkg::IDX_W'(gchg_pkg::NUM_DENOMS - 1));
    sts.bit_zero     = (bitn == '0);
    sts.zero_amt     = (price == '0) || (paid == '0);
    sts.drawer_short = (paid >= price) && (gchg_pkg::TOT_W'(change) > acc);
    sts.pay_short    = (paid < price);
    sts.exact        = (change == '0);
    sts.cnt_nz       = (cnt[idx] != '0);
    sts.later_nz     = later_nz;
    sts.any_nz       = any_nz;
    sts.out_free     = !out_valid || out_ready;
  end

  // denomination values and note stock
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gchg_pkg::NUM_DENOMS; i++) begin
        value[i] <= gchg_pkg::reset_value(i);
        stock[i] <= gchg_pkg::INITIAL_STOCK;
      end
    end else begin
      if (cfg_wr_en) begin
        for (int i = 0; i < gchg_pkg::NUM_DENOMS; i++) begin
          if ((i < gchg_pkg::NUM_REGS) && (cfg_index == gchg_pkg::CFG_IDX_W'(i))) begin
            value[i] <= cfg_data;
          end
        end
      end
      if (cmd.walk_store) begin
        stock[idx] <= cur_stock - q;
      end
    end
  end

  // sale, total and walk datapath
  always_ff @(posedge clk) begin
    if (cmd.load_sale) begin
      price <= sale_price;
      paid  <= sale_paid;
      acc   <= '0;
    end else if (cmd.tot_acc) begin
      acc <= acc + gchg_pkg::TOT_W'(prod);
    end
    if (cmd.tot_mul) begin
      prod <= gchg_pkg::PROD_W'(cur_value) * gchg_pkg::PROD_W'(cur_stock);
    end
    if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + gchg_pkg::IDX_W'(1);
    end
    if (cmd.rest_load) begin
      rest <= change;
    end else if (cmd.walk_step && take) begin
      rest <= rest - sub[gchg_pkg::AMT_W-1:0];
    end
    if (cmd.walk_init) begin
      q    <= '0;
      bitn <= gchg_pkg::BIT_W'(gchg_pkg::CNT_W - 1);
    end else if (cmd.walk_step) begin
      if (take) begin
        q <= trial;
      end
      bitn <= bitn - gchg_pkg::BIT_W'(1);
    end
    if (cmd.walk_store) begin
      cnt[idx] <= q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_code;
      case (cmd.out_code)
        gchg_pkg::ST_ISSUED: begin
          out_denom_index <= gchg_pkg::IDX_OUT_W'(idx);
          out_note_count  <= cnt[idx];
          out_change_due  <= change;
          out_unpaid_rest <= later_nz ? '0 : rest;
          out_last        <= !later_nz;
        end
        gchg_pkg::ST_DRAWER: begin
          out_denom_index <= '0;
          out_note_count  <= '0;
          out_change_due  <= change;
          out_unpaid_rest <= '0;
          out_last        <= 1'b1;
        end
        default: begin
          out_denom_index <= '0;
          out_note_count  <= '0;
          out_change_due  <= '0;
          out_unpaid_rest <= '0;
          out_last        <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== design/gchg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_checker
// port-level assertions on the dispenser, bound to the top level
// ----------------------------------------------------------------------------
`include "greedy_change_dispenser_core_macros.svh"

module gchg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           sale_valid,
  input logic                           sale_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [gchg_pkg::STAT_W-1:0]    result_status,
  input logic [gchg_pkg::CNT_W-1:0]     result_note_count,
  input logic [gchg_pkg::AMT_W-1:0]     result_unpaid_rest,
  input logic                           result_last
);

  `GCHG_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_status) && $stable(result_note_count) && $stable(result_last))
  `GCHG_ASSERT_NXT(a_busy_after_sale, clk, rst, sale_valid && sale_ready, !sale_ready)
  `GCHG_ASSERT_IMP(a_reject_is_last, clk, rst, result_valid && (result_status != gchg_pkg::ST_ISSUED), result_last)
  `GCHG_ASSERT_IMP(a_rest_on_last, clk, rst, result_valid && !result_last, result_unpaid_rest == '0)
  `GCHG_ASSERT_IMP(a_notes_or_last, clk, rst, result_valid && (result_status == gchg_pkg::ST_ISSUED), (result_note_count != '0) || result_last)

endmodule

bind greedy_change_dispenser_core gchg_checker u_gchg_checker (
  .clk                (clk),
  .rst                (rst),
  .sale_valid         (sale.valid),
  .sale_ready         (sale.ready),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_status      (result.status),
  .result_note_count  (result.note_count),
  .result_unpaid_rest (result.unpaid_rest),
  .result_last        (result.last)
);
